// File: rtl/core/pcps_pkg.sv
`timescale 1ns / 1ps

package pcps_pkg;

  // Stream field widths
  localparam int CoordW = 12;
  localparam int TimeW  = 32;
  localparam int RecipW = 25;
  localparam int ChanW  = 8;

  localparam int InDataW  = 56;
  localparam int OutDataW = 24;

  // Pipeline split between the phase front end and the per-channel back end
  localparam int PhaseStages = 7;
  localparam int ChanStages  = 5;
  localparam int NumStages   = PhaseStages + ChanStages;

  // Internal widths
  localparam int MagW  = 24;  // magnitude of a centred Q1.24 coordinate
  localparam int PhW   = 46;  // phase times 1/(2*pi), the bits that reach the turn count
  localparam int MaxDim = 4096;

  localparam logic [RecipW-1:0] RecipWidthRst  = 25'd26214;
  localparam logic [RecipW-1:0] RecipHeightRst = 25'd34953;

  localparam longint HalfQ24     = 64'd8388608;
  localparam longint InvTwoPiQ30 = 64'd170891319;

  // Channel offsets 0.9, 0.5 and 0.1 in Q16.16, already scaled by 1/(2*pi)
  localparam logic [PhW-1:0] OffRed   = PhW'(64'd58982 * InvTwoPiQ30);
  localparam logic [PhW-1:0] OffGreen = PhW'(64'd32768 * InvTwoPiQ30);
  localparam logic [PhW-1:0] OffBlue  = PhW'(64'd6554 * InvTwoPiQ30);

  typedef enum logic {
    CfgRecipWidth  = 1'b0,
    CfgRecipHeight = 1'b1
  } cfg_reg_e;

  typedef logic [PhaseStages-1:0] phase_en_t;
  typedef logic [ChanStages-1:0]  chan_en_t;

endpackage

// File: rtl/core/pcps_phase.sv
`timescale 1ns / 1ps

module pcps_phase (
  input  logic                         clk_i,
  input  pcps_pkg::phase_en_t          en_i,
  input  logic [pcps_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [pcps_pkg::CoordW-1:0]  pixel_y_i,
  input  logic [pcps_pkg::TimeW-1:0]   frame_time_i,
  input  logic [pcps_pkg::RecipW-1:0]  recip_width_i,
  input  logic [pcps_pkg::RecipW-1:0]  recip_height_i,
  output logic [pcps_pkg::PhW-1:0]     phase_o
);
  import pcps_pkg::*;

  localparam int ProdW = CoordW + RecipW;

  // Sign and magnitude of the centred coordinate, saturated above at 2^24-1.
  // The lower bound of the Q1.24 range cannot be reached from a non-negative product.
  function automatic logic [MagW:0] centre_mag(input logic [ProdW-1:0] p);
    logic [MagW:0] r;
    if (p < ProdW'(HalfQ24)) begin
      r = {1'b1, MagW'(ProdW'(HalfQ24) - p)};
    end else if (p > ProdW'(3 * HalfQ24 - 1)) begin
      r = {1'b0, {MagW{1'b1}}};
    end else begin
      r = {1'b0, MagW'(p - ProdW'(HalfQ24))};
    end
    return r;
  endfunction

  // Stage 0: scale coordinates by the reciprocals
  logic [ProdW-1:0] px_q, py_q;
  logic [TimeW-1:0] t0_q;
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px_q <= ProdW'(pixel_x_i) * ProdW'(recip_width_i);
      py_q <= ProdW'(pixel_y_i) * ProdW'(recip_height_i);
      t0_q <= frame_time_i;
    end
  end

  // Stage 1: centre and saturate
  logic [MagW:0]    cu_d, cv_d;
  logic [MagW-1:0]  mu1_q, mv1_q;
  logic             su1_q, sv1_q;
  logic [TimeW-1:0] t1_q;
  assign cu_d = centre_mag(px_q);
  assign cv_d = centre_mag(py_q);
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      su1_q <= cu_d[MagW];
      mu1_q <= cu_d[MagW-1:0];
      sv1_q <= cv_d[MagW];
      mv1_q <= cv_d[MagW-1:0];
      t1_q  <= t0_q;
    end
  end

  // Stage 2: squares
  logic [2*MagW-1:0] squ_d, sqv_d;
  logic [MagW-1:0]   mu2_q, mv2_q, u2_q, v2_q;
  logic              su2_q, sv2_q;
  logic [TimeW-1:0]  t2_q;
  assign squ_d = (2*MagW)'(mu1_q) * (2*MagW)'(mu1_q);
  assign sqv_d = (2*MagW)'(mv1_q) * (2*MagW)'(mv1_q);
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      u2_q  <= squ_d[2*MagW-1:MagW];
      v2_q  <= sqv_d[2*MagW-1:MagW];
      mu2_q <= mu1_q;
      mv2_q <= mv1_q;
      su2_q <= su1_q;
      sv2_q <= sv1_q;
      t2_q  <= t1_q;
    end
  end

  // Stage 3: cubes
  logic [2*MagW-1:0] cbu_d, cbv_d;
  logic [MagW-1:0]   u3_q, v3_q;
  logic              su3_q, sv3_q;
  logic [TimeW-1:0]  t3_q;
  assign cbu_d = (2*MagW)'(u2_q) * (2*MagW)'(mu2_q);
  assign cbv_d = (2*MagW)'(v2_q) * (2*MagW)'(mv2_q);
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      u3_q  <= cbu_d[2*MagW-1:MagW];
      v3_q  <= cbv_d[2*MagW-1:MagW];
      su3_q <= su2_q;
      sv3_q <= sv2_q;
      t3_q  <= t2_q;
    end
  end

  // Stage 4: signed sum of the cubes
  localparam int SumW = MagW + 2;
  logic signed [SumW-1:0] tu_d, tv_d, s_d, s4_q;
  logic [TimeW-1:0]       t4_q;
  assign tu_d = su3_q ? -$signed({2'b00, u3_q}) : $signed({2'b00, u3_q});
  assign tv_d = sv3_q ? -$signed({2'b00, v3_q}) : $signed({2'b00, v3_q});
  assign s_d  = tu_d + tv_d;
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s4_q <= s_d;
      t4_q <= t3_q;
    end
  end

  // Stage 5: scale by 25, drop to Q16.16 on the magnitude, and apply to the time
  localparam int MdW = 22;
  logic [SumW-2:0]  ms_d;
  logic [SumW+3:0]  m25_d;
  logic [MdW-1:0]   md_d;
  logic [TimeW-1:0] q_d, q5_q;
  assign ms_d  = s4_q[SumW-1] ? (SumW-1)'(-s4_q) : (SumW-1)'(s4_q);
  assign m25_d = (SumW+4)'(ms_d) * (SumW+4)'(25);
  assign md_d  = m25_d[MdW+7:8];
  assign q_d   = s4_q[SumW-1] ? t4_q + TimeW'(md_d) : t4_q - TimeW'(md_d);
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      q5_q <= q_d;
    end
  end

  // Stage 6: phase times 1/(2*pi); only the low bits matter for the turn count
  localparam int QkW = TimeW + 29;
  logic signed [QkW-1:0] qk_d;
  logic [PhW-1:0]        qk_q;
  assign qk_d = $signed(q5_q) * $signed({1'b0, 28'(InvTwoPiQ30)});
  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      qk_q <= qk_d[PhW-1:0];
    end
  end

  assign phase_o = qk_q;

endmodule

// File: rtl/core/pcps_chan.sv
`timescale 1ns / 1ps

module pcps_chan (
  input  logic                       clk_i,
  input  pcps_pkg::chan_en_t         en_i,
  input  logic [pcps_pkg::PhW-1:0]   phase_i,
  input  logic [pcps_pkg::PhW-1:0]   offset_i,
  output logic [pcps_pkg::ChanW-1:0] level_o
);
  import pcps_pkg::*;

  localparam int TurnW = 24;
  localparam int CosW  = 25;
  localparam int ZW    = 26;
  localparam int XW    = 27;

  // Stage 0: turns, quarter-turn shift, fold to a signed offset around half a turn
  logic [PhW-1:0]   a_d;
  logic [TurnW-1:0] v_d, my_d, my0_q;
  logic             neg_d, neg0_q;
  assign a_d   = phase_i + offset_i;
  assign v_d   = a_d[PhW-1:PhW-TurnW] + TurnW'(24'h400000);
  assign neg_d = ~v_d[TurnW-1];
  assign my_d  = neg_d ? TurnW'(24'h800000) - v_d : {1'b0, v_d[TurnW-2:0]};
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      my0_q  <= my_d;
      neg0_q <= neg_d;
    end
  end

  // Stage 1: parabola |y| * (1/2 - |y|)
  logic [2*TurnW-1:0] par_d;
  logic [CosW-1:0]    mag1_q;
  logic               neg1_q;
  assign par_d = (2*TurnW)'(my0_q) * (2*TurnW)'(TurnW'(24'h800000) - my0_q);
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mag1_q <= par_d[44:20];
      neg1_q <= neg0_q;
    end
  end

  // Stage 2: lift to [0, 2], times 13, and the divide by four of the divide by twenty
  logic [ZW-1:0]   z_d;
  logic [XW+1:0]   n_d;
  logic [XW-1:0]   x2_q;
  assign z_d = neg1_q ? ZW'(26'h1000000) + ZW'(mag1_q) : ZW'(26'h1000000) - ZW'(mag1_q);
  assign n_d = ((XW+2)'(z_d) << 3) + ((XW+2)'(z_d) << 2) + (XW+2)'(z_d);
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      x2_q <= n_d[XW+1:2];
    end
  end

  // Stage 3: divide by five through the reciprocal multiply
  logic [XW+31:0] r5_d;
  logic [CosW-1:0] w3_q;
  assign r5_d = (XW+32)'(x2_q) * (XW+32)'(32'hCCCCCCCD);
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      w3_q <= r5_d[XW+31:34];
    end
  end

  // Stage 4: clamp to one and scale to a byte
  logic [CosW-1:0] w_d;
  logic [CosW+7:0] b_d;
  logic [ChanW-1:0] lvl4_q;
  assign w_d = (w3_q > CosW'(25'h1000000)) ? CosW'(25'h1000000) : w3_q;
  assign b_d = {w_d, 8'h00} - (CosW+8)'(w_d);
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      lvl4_q <= b_d[31:24];
    end
  end

  assign level_o = lvl4_q;

endmodule

// File: rtl/core/procedural_color_pixel_shader_core.sv
`timescale 1ns / 1ps
// Procedural colour shader: one pixel coordinate and a frame time in, one RGB byte triple out.
// Slave side takes requests carrying pixel_x, pixel_y and frame_time; the master side
// delivers red, green and blue. The reciprocals of the image width and height are loaded
// through the plain write port (index 0 width, index 1 height); the user must do so only
// while the block is idle, as the block itself does not enforce it. The datapath is twelve
// register stages: seven build the phase from the centred coordinates and the time, five
// per colour channel evaluate the parabolic cosine and the byte mapping. Throughput is one
// pixel per clock for as long as the receiver keeps m_axis_tready high.
// Each stage holds a valid bit and advances whenever it is empty or the stage after it
// advances, so a stalled receiver first lets bubbles close up and only then pushes back
// on s_axis_tready; no result is lost or repeated. The last stage is the output register.
// Reset clears all valid bits and loads the reciprocals for a 640 by 480 image.

module procedural_color_pixel_shader_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pixel_x [11:0], pixel_y [23:12], frame_time [55:24]
  input  logic [pcps_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [pcps_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  pcps_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [pcps_pkg::RecipW-1:0]    cfg_data_i
);
  import pcps_pkg::*;

  // Configuration
  logic [RecipW-1:0] recip_width_q, recip_height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_width_q  <= RecipWidthRst;
      recip_height_q <= RecipHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRecipWidth:  recip_width_q  <= cfg_data_i;
        CfgRecipHeight: recip_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and the advance chain from the output back to the input
  logic [NumStages-1:0] v_q, en;
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NumStages-1];

  // Datapath
  phase_en_t      phase_en;
  chan_en_t       chan_en;
  logic [PhW-1:0] phase;
  logic [ChanW-1:0] red, green, blue;

  assign phase_en = en[PhaseStages-1:0];
  assign chan_en  = en[NumStages-1:PhaseStages];

  pcps_phase u_phase (
    .clk_i          (clk_i),
    .en_i           (phase_en),
    .pixel_x_i      (s_axis_tdata[CoordW-1:0]),
    .pixel_y_i      (s_axis_tdata[2*CoordW-1:CoordW]),
    .frame_time_i   (s_axis_tdata[2*CoordW+TimeW-1:2*CoordW]),
    .recip_width_i  (recip_width_q),
    .recip_height_i (recip_height_q),
    .phase_o        (phase)
  );

  pcps_chan u_chan_red (
    .clk_i    (clk_i),
    .en_i     (chan_en),
    .phase_i  (phase),
    .offset_i (OffRed),
    .level_o  (red)
  );

  pcps_chan u_chan_green (
    .clk_i    (clk_i),
    .en_i     (chan_en),
    .phase_i  (phase),
    .offset_i (OffGreen),
    .level_o  (green)
  );

  pcps_chan u_chan_blue (
    .clk_i    (clk_i),
    .en_i     (chan_en),
    .phase_i  (phase),
    .offset_i (OffBlue),
    .level_o  (blue)
  );

  assign m_axis_tdata = {blue, green, red};

  // An empty output stage never pushes back on the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // A taking receiver lets the whole pipeline advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the receiver takes results");

  // An accepted request occupies the first stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted request did not enter the pipeline");

  // Input is refused only when every stage holds a request and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> ((&v_q) && !m_axis_tready))
    else $error("input refused while a bubble remains");

endmodule
